FILE: design/first_fit_block_allocator_core_assert.svh
// Assertion macros used by the allocator RTL.
// Needs nothing else; included by ffba_ctrl, which checks its own logic.
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_CORE_ASSERT_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FFBA_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define FFBA_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/ffba_pkg.sv
// Package of the first-fit block allocator: constants, codes and types.
// No dependencies; used by ffba_ctrl and the top level.
package ffba_pkg;

	localparam int MAX_BLOCKS_DEF = 32;
	localparam int ADDR_WIDTH_DEF = 32;
	localparam int DATA_W = 32;
	localparam int SIZE_W = 24;
	localparam int HDR_W = 8;
	localparam int CFG_IDX_W = 2;

	localparam logic [DATA_W-1:0] HEAP_BASE_RST = 32'd0;
	localparam logic [HDR_W-1:0] HEADER_SIZE_RST = 8'd56;
	localparam logic [SIZE_W-1:0] COPY_THRESHOLD_RST = 24'd4096;
	localparam logic [SIZE_W-1:0] SIZE_MAX = 24'hFFFFFF;

	typedef enum logic [1:0] {
		OP_ALLOC = 2'd0,
		OP_FREE = 2'd1,
		OP_RESIZE = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_FULL = 2'd2
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_HEAP_BASE = 2'd0,
		CFG_HEADER_SIZE = 2'd1,
		CFG_COPY_THRESHOLD = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic [DATA_W-1:0] heap_base;
		logic [HDR_W-1:0] header_size;
		logic [SIZE_W-1:0] copy_threshold;
	} cfg_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_ALLOC_RD,
		S_ALLOC_CHK,
		S_APPEND,
		S_POST,
		S_LOC_RD,
		S_LOC_CHK,
		S_TRIM_RD,
		S_TRIM_CHK,
		S_RSZ_DEC,
		S_GROW_RD,
		S_GROW_CHK,
		S_GROW_END,
		S_DROP_RD,
		S_DROP_WR,
		S_GROW_FIN,
		S_INS_RD,
		S_INS_WR,
		S_OUT
	} state_t;

endpackage

FILE: design/ffba_if.sv
// Request and response channel interfaces of the allocator.
// Depends on nothing; payload widths match the allocator fields.
interface ffba_req_if;
	logic valid;
	logic ready;
	logic [1:0] operation;
	logic [31:0] block_address;
	logic [23:0] request_size;

	modport source (output valid, output operation, output block_address,
		output request_size, input ready);
	modport sink (input valid, input operation, input block_address,
		input request_size, output ready);
endinterface

interface ffba_rsp_if;
	logic valid;
	logic ready;
	logic [31:0] result_address;
	logic [1:0] status;
	logic copy_needed;
	logic [31:0] copy_source;
	logic [23:0] copy_length;

	modport source (output valid, output result_address, output status,
		output copy_needed, output copy_source, output copy_length, input ready);
	modport sink (input valid, input result_address, input status,
		input copy_needed, input copy_source, input copy_length, output ready);
endinterface

FILE: design/ffba_table.sv
// Block table memory: one write port, one read port with registered data.
// No dependencies.
module ffba_table #(
	parameter int DEPTH = 32,
	parameter int EW = 57,
	localparam int IW = $clog2(DEPTH)
) (
	input logic clk,
	input logic we,
	input logic [IW-1:0] waddr,
	input logic [EW-1:0] wdata,
	input logic [IW-1:0] raddr,
	output logic [EW-1:0] rdata
);

	logic [EW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: design/ffba_ctrl.sv
// Sequencer and shared datapath of the allocator: scans, shifts and edits the table.
// Depends on ffba_pkg, ffba_if and the assertion macro header.
`include "first_fit_block_allocator_core_assert.svh"

module ffba_ctrl #(
	parameter int MAX_BLOCKS = ffba_pkg::MAX_BLOCKS_DEF,
	parameter int ADDR_WIDTH = ffba_pkg::ADDR_WIDTH_DEF,
	localparam int IW = $clog2(MAX_BLOCKS),
	localparam int CW = $clog2(MAX_BLOCKS + 1),
	localparam int EW = ADDR_WIDTH + ffba_pkg::SIZE_W + 1
) (
	input logic clk,
	input logic arst_n,
	input ffba_pkg::cfg_t cfg,
	input logic base_wr,
	input logic [ffba_pkg::DATA_W-1:0] base_data,
	ffba_req_if.sink req,
	ffba_rsp_if.source rsp,
	output logic mem_we,
	output logic [IW-1:0] mem_waddr,
	output logic [EW-1:0] mem_wdata,
	output logic [IW-1:0] mem_raddr,
	input logic [EW-1:0] mem_rdata
);

	localparam int AW = ADDR_WIDTH;
	localparam int SW = ffba_pkg::SIZE_W;
	localparam int XW = (AW > ffba_pkg::DATA_W) ? AW : ffba_pkg::DATA_W;
	localparam int AVW = SW + CW + 1;

	ffba_pkg::state_t state_q, state_d;
	logic [CW-1:0] count_q;
	logic [AW-1:0] brk_q;

	logic [1:0] op_q;
	logic [31:0] addr_q;
	logic [SW-1:0] size_q;
	logic move_q, reloc_q;
	logic [CW-1:0] k_q, idx_q, j_q, n_q, ins_pos_q;
	logic [AW-1:0] ent_addr_q;
	logic [SW-1:0] ent_size_q;
	logic ent_free_q;
	logic [SW-1:0] old_q;
	logic [AVW-1:0] avail_q;
	logic [EW-1:0] ins_ent_q;
	logic [31:0] res_q, src_q;
	ffba_pkg::status_t st_q;
	logic copy_q;
	logic [SW-1:0] len_q;

	logic [AW-1:0] rd_addr;
	logic [SW-1:0] rd_size;
	logic rd_free;
	logic [AW-1:0] hdr_a;
	logic [9:0] hdr3;
	logic room, fit_a, split_a, split_r, match, last, over_thr, rem_big, drop_more;
	logic grow_more;
	logic [SW-1:0] spare_a, spare_r, avail_sat;
	logic [AVW-1:0] rem;
	logic [CW-1:0] km1, kpn, idx1, cm1;
	logic [CW:0] kpn_w;
	logic accept;

	assign rd_addr = mem_rdata[EW-1 -: AW];
	assign rd_size = mem_rdata[SW:1];
	assign rd_free = mem_rdata[0];
	assign hdr_a = AW'(cfg.header_size);
	assign hdr3 = {2'b00, cfg.header_size} + {1'b0, cfg.header_size, 1'b0};
	assign room = count_q < CW'(MAX_BLOCKS);
	assign fit_a = rd_free && (rd_size >= size_q);
	assign spare_a = rd_size - size_q;
	assign split_a = (spare_a > SW'(hdr3)) && room;
	assign spare_r = ent_size_q - size_q;
	assign split_r = (spare_r > SW'(hdr3)) && room;
	assign match = XW'(rd_addr) == XW'(addr_q);
	assign idx1 = idx_q + CW'(1);
	assign last = idx1 == count_q;
	assign over_thr = ent_size_q > cfg.copy_threshold;
	assign rem = avail_q - AVW'(size_q);
	assign rem_big = rem > AVW'(hdr3);
	assign avail_sat = (avail_q > AVW'(ffba_pkg::SIZE_MAX)) ? ffba_pkg::SIZE_MAX
		: avail_q[SW-1:0];
	assign km1 = k_q - CW'(1);
	assign cm1 = count_q - CW'(1);
	assign kpn_w = {1'b0, k_q} + {1'b0, n_q};
	assign kpn = kpn_w[CW-1:0];
	assign drop_more = kpn_w < {1'b0, count_q};
	assign grow_more = (avail_q < AVW'(size_q)) && (j_q < count_q);
	assign accept = req.valid && req.ready;

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ffba_pkg::S_IDLE: begin
				if (accept) begin
					case (req.operation)
						ffba_pkg::OP_ALLOC: state_d = ffba_pkg::S_ALLOC_RD;
						ffba_pkg::OP_FREE: state_d = (req.block_address == '0)
							? ffba_pkg::S_OUT : ffba_pkg::S_LOC_RD;
						ffba_pkg::OP_RESIZE: state_d = (req.block_address == '0)
							? ffba_pkg::S_ALLOC_RD : ffba_pkg::S_LOC_RD;
						default: state_d = ffba_pkg::S_OUT;
					endcase
				end
			end
			ffba_pkg::S_ALLOC_RD: state_d = (k_q < count_q) ? ffba_pkg::S_ALLOC_CHK
				: ffba_pkg::S_APPEND;
			ffba_pkg::S_ALLOC_CHK: begin
				if (fit_a) begin
					state_d = split_a ? ffba_pkg::S_INS_RD : ffba_pkg::S_POST;
				end else begin
					state_d = ffba_pkg::S_ALLOC_RD;
				end
			end
			ffba_pkg::S_APPEND: state_d = room ? ffba_pkg::S_POST : ffba_pkg::S_OUT;
			ffba_pkg::S_POST: state_d = move_q ? ffba_pkg::S_LOC_RD : ffba_pkg::S_OUT;
			ffba_pkg::S_LOC_RD: state_d = (k_q < count_q) ? ffba_pkg::S_LOC_CHK
				: ffba_pkg::S_OUT;
			ffba_pkg::S_LOC_CHK: begin
				if (!match) begin
					state_d = ffba_pkg::S_LOC_RD;
				end else if (reloc_q) begin
					state_d = ffba_pkg::S_OUT;
				end else if (op_q == ffba_pkg::OP_FREE) begin
					state_d = ffba_pkg::S_TRIM_RD;
				end else begin
					state_d = ffba_pkg::S_RSZ_DEC;
				end
			end
			ffba_pkg::S_TRIM_RD: state_d = (count_q == '0) ? ffba_pkg::S_OUT
				: ffba_pkg::S_TRIM_CHK;
			ffba_pkg::S_TRIM_CHK: state_d = rd_free ? ffba_pkg::S_TRIM_RD : ffba_pkg::S_OUT;
			ffba_pkg::S_RSZ_DEC: begin
				if (size_q <= ent_size_q) begin
					state_d = split_r ? ffba_pkg::S_INS_RD : ffba_pkg::S_OUT;
				end else if (over_thr) begin
					state_d = last ? ffba_pkg::S_OUT : ffba_pkg::S_GROW_RD;
				end else begin
					state_d = ffba_pkg::S_ALLOC_RD;
				end
			end
			ffba_pkg::S_GROW_RD: state_d = grow_more ? ffba_pkg::S_GROW_CHK
				: ffba_pkg::S_GROW_END;
			ffba_pkg::S_GROW_CHK: state_d = rd_free ? ffba_pkg::S_GROW_RD
				: ffba_pkg::S_GROW_END;
			ffba_pkg::S_GROW_END: state_d = (avail_q < AVW'(size_q)) ? ffba_pkg::S_ALLOC_RD
				: ffba_pkg::S_DROP_RD;
			ffba_pkg::S_DROP_RD: state_d = drop_more ? ffba_pkg::S_DROP_WR
				: ffba_pkg::S_GROW_FIN;
			ffba_pkg::S_DROP_WR: state_d = ffba_pkg::S_DROP_RD;
			ffba_pkg::S_GROW_FIN: state_d = rem_big ? ffba_pkg::S_INS_RD : ffba_pkg::S_OUT;
			ffba_pkg::S_INS_RD: state_d = (k_q > ins_pos_q) ? ffba_pkg::S_INS_WR
				: ffba_pkg::S_POST;
			ffba_pkg::S_INS_WR: state_d = ffba_pkg::S_INS_RD;
			ffba_pkg::S_OUT: state_d = rsp.ready ? ffba_pkg::S_IDLE : ffba_pkg::S_OUT;
			default: state_d = ffba_pkg::S_IDLE;
		endcase
	end

	// Table port and handshake outputs.
	always_comb begin
		mem_we = 1'b0;
		mem_waddr = '0;
		mem_wdata = '0;
		mem_raddr = '0;
		case (state_q)
			ffba_pkg::S_ALLOC_RD: mem_raddr = k_q[IW-1:0];
			ffba_pkg::S_ALLOC_CHK: begin
				mem_we = fit_a;
				mem_waddr = k_q[IW-1:0];
				mem_wdata = {rd_addr, split_a ? size_q : rd_size, 1'b0};
			end
			ffba_pkg::S_APPEND: begin
				mem_we = room;
				mem_waddr = count_q[IW-1:0];
				mem_wdata = {brk_q + hdr_a, size_q, 1'b0};
			end
			ffba_pkg::S_LOC_RD: mem_raddr = k_q[IW-1:0];
			ffba_pkg::S_LOC_CHK: begin
				mem_we = match && (reloc_q || op_q == ffba_pkg::OP_FREE);
				mem_waddr = k_q[IW-1:0];
				mem_wdata = {rd_addr, rd_size, 1'b1};
			end
			ffba_pkg::S_TRIM_RD: mem_raddr = cm1[IW-1:0];
			ffba_pkg::S_RSZ_DEC: begin
				mem_we = (size_q <= ent_size_q) ? split_r : (over_thr && last);
				mem_waddr = idx_q[IW-1:0];
				mem_wdata = {ent_addr_q, size_q, ent_free_q};
			end
			ffba_pkg::S_GROW_RD: mem_raddr = j_q[IW-1:0];
			ffba_pkg::S_DROP_RD: mem_raddr = kpn[IW-1:0];
			ffba_pkg::S_DROP_WR: begin
				mem_we = 1'b1;
				mem_waddr = k_q[IW-1:0];
				mem_wdata = mem_rdata;
			end
			ffba_pkg::S_GROW_FIN: begin
				mem_we = 1'b1;
				mem_waddr = idx_q[IW-1:0];
				mem_wdata = {ent_addr_q, rem_big ? size_q : avail_sat, ent_free_q};
			end
			ffba_pkg::S_INS_RD: begin
				mem_raddr = km1[IW-1:0];
				mem_we = !(k_q > ins_pos_q);
				mem_waddr = ins_pos_q[IW-1:0];
				mem_wdata = ins_ent_q;
			end
			ffba_pkg::S_INS_WR: begin
				mem_we = 1'b1;
				mem_waddr = k_q[IW-1:0];
				mem_wdata = mem_rdata;
			end
			default: ;
		endcase
	end

	assign req.ready = state_q == ffba_pkg::S_IDLE;
	assign rsp.valid = state_q == ffba_pkg::S_OUT;
	assign rsp.result_address = res_q;
	assign rsp.status = st_q;
	assign rsp.copy_needed = copy_q;
	assign rsp.copy_source = src_q;
	assign rsp.copy_length = len_q;

	// Control state: sequencer, entry count and break pointer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ffba_pkg::S_IDLE;
			count_q <= '0;
			brk_q <= AW'(ffba_pkg::HEAP_BASE_RST);
		end else begin
			state_q <= state_d;
			case (state_q)
				ffba_pkg::S_IDLE: begin
					if (base_wr && count_q == '0) begin
						brk_q <= AW'(base_data);
					end
				end
				ffba_pkg::S_APPEND: begin
					if (room) begin
						count_q <= count_q + CW'(1);
						brk_q <= brk_q + hdr_a + AW'(size_q);
					end
				end
				ffba_pkg::S_TRIM_CHK: begin
					if (rd_free) begin
						count_q <= cm1;
						brk_q <= rd_addr - hdr_a;
					end
				end
				ffba_pkg::S_RSZ_DEC: begin
					if (size_q > ent_size_q && over_thr && last) begin
						brk_q <= ent_addr_q + AW'(size_q);
					end
				end
				ffba_pkg::S_DROP_RD: begin
					if (!drop_more) begin
						count_q <= count_q - n_q;
					end
				end
				ffba_pkg::S_INS_RD: begin
					if (!(k_q > ins_pos_q)) begin
						count_q <= count_q + CW'(1);
					end
				end
				default: ;
			endcase
		end
	end

	// Working registers of the current item.
	always_ff @(posedge clk) begin
		case (state_q)
			ffba_pkg::S_IDLE: begin
				if (accept) begin
					op_q <= req.operation;
					addr_q <= req.block_address;
					size_q <= req.request_size;
					move_q <= 1'b0;
					reloc_q <= 1'b0;
					k_q <= '0;
					res_q <= '0;
					st_q <= ffba_pkg::ST_OK;
					copy_q <= 1'b0;
					src_q <= '0;
					len_q <= '0;
					old_q <= '0;
				end
			end
			ffba_pkg::S_ALLOC_CHK: begin
				if (fit_a) begin
					res_q <= 32'(XW'(rd_addr));
					ins_pos_q <= k_q + CW'(1);
					ins_ent_q <= {rd_addr + AW'(size_q) + hdr_a, spare_a - SW'(cfg.header_size),
						1'b1};
					k_q <= count_q;
				end else begin
					k_q <= k_q + CW'(1);
				end
			end
			ffba_pkg::S_APPEND: begin
				if (room) begin
					res_q <= 32'(XW'(brk_q + hdr_a));
				end else begin
					st_q <= ffba_pkg::ST_FULL;
				end
			end
			ffba_pkg::S_POST: begin
				if (move_q) begin
					copy_q <= 1'b1;
					src_q <= addr_q;
					len_q <= (old_q < size_q) ? old_q : size_q;
					reloc_q <= 1'b1;
					k_q <= '0;
				end
			end
			ffba_pkg::S_LOC_RD: begin
				if (!(k_q < count_q) && !reloc_q) begin
					st_q <= ffba_pkg::ST_NOT_FOUND;
				end
			end
			ffba_pkg::S_LOC_CHK: begin
				if (match) begin
					idx_q <= k_q;
					ent_addr_q <= rd_addr;
					ent_size_q <= rd_size;
					ent_free_q <= rd_free;
				end else begin
					k_q <= k_q + CW'(1);
				end
			end
			ffba_pkg::S_RSZ_DEC: begin
				old_q <= ent_size_q;
				avail_q <= AVW'(ent_size_q);
				j_q <= idx1;
				// A shrink or a grow in place never moves the block.
				if (size_q <= ent_size_q) begin
					move_q <= 1'b0;
					res_q <= addr_q;
					ins_pos_q <= idx1;
					ins_ent_q <= {ent_addr_q + AW'(size_q) + hdr_a,
						spare_r - SW'(cfg.header_size), 1'b1};
					k_q <= count_q;
				end else if (over_thr && last) begin
					move_q <= 1'b0;
					res_q <= addr_q;
					k_q <= '0;
				end else begin
					move_q <= 1'b1;
					k_q <= '0;
				end
			end
			ffba_pkg::S_GROW_CHK: begin
				if (rd_free) begin
					avail_q <= avail_q + AVW'(cfg.header_size) + AVW'(rd_size);
					j_q <= j_q + CW'(1);
				end
			end
			ffba_pkg::S_GROW_END: begin
				n_q <= j_q - idx1;
				if (avail_q < AVW'(size_q)) begin
					k_q <= '0;
				end else begin
					k_q <= idx1;
				end
			end
			ffba_pkg::S_DROP_WR: k_q <= k_q + CW'(1);
			ffba_pkg::S_GROW_FIN: begin
				res_q <= addr_q;
				move_q <= 1'b0;
				ins_pos_q <= idx1;
				ins_ent_q <= {ent_addr_q + AW'(size_q) + hdr_a,
					SW'(rem - AVW'(cfg.header_size)), 1'b1};
				k_q <= count_q;
			end
			ffba_pkg::S_INS_WR: k_q <= km1;
			default: ;
		endcase
	end

	`FFBA_ASSERT_NOW(a_count_bound, clk, arst_n, 1'b1, count_q <= CW'(MAX_BLOCKS), "entry count above table depth")
	`FFBA_ASSERT_NOW(a_write_bound, clk, arst_n, mem_we, CW'(mem_waddr) < CW'(MAX_BLOCKS), "table write beyond depth")
	`FFBA_ASSERT_NOW(a_full_status, clk, arst_n, rsp.valid && rsp.status == ffba_pkg::ST_FULL, count_q == CW'(MAX_BLOCKS), "full status with free table rows")
	`FFBA_ASSERT_NOW(a_copy_ok, clk, arst_n, rsp.valid && rsp.copy_needed, rsp.status == ffba_pkg::ST_OK, "copy reported on a failed request")
	`FFBA_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, accept, !req.ready, "ready again right after an item was taken")

endmodule

FILE: design/first_fit_block_allocator_core.sv
// Top level of the first-fit block allocator: configuration registers and wiring.
// Depends on ffba_pkg, ffba_if, ffba_table and ffba_ctrl.
//
// Requests arrive on the req channel (allocate, free or resize) and each item
// produces exactly one result item on the rsp channel. The block handles one
// item at a time: req.ready is high only while the sequencer is idle, and it
// stays low until the result has been taken on rsp.
// Timing depends on the table contents. A table scan reads one entry at a time
// because the table memory has one read port with registered read data; every
// insert or removal shifts entries one at a time as well. A free scans the
// table for the block and then trims free entries from the tail; a resize that
// moves the block scans the table up to three times and shifts it once.
// The result is held in registers while rsp.valid is high; if the receiver
// stalls, the block simply waits with its state unchanged.
// Reset clears the entry count and loads the break pointer with the reset heap
// base; table rows need no clearing since only rows below the count are read.
// Configuration writes on cfg_we/cfg_index/cfg_data take effect at once and
// must only come while the block is idle; a heap base write with an empty
// table also moves the break pointer.
module first_fit_block_allocator_core #(
	parameter int MAX_BLOCKS = ffba_pkg::MAX_BLOCKS_DEF,
	parameter int ADDR_WIDTH = ffba_pkg::ADDR_WIDTH_DEF
) (
	input logic clk,
	input logic arst_n,
	ffba_req_if.sink req,
	ffba_rsp_if.source rsp,
	input logic cfg_we,
	input logic [ffba_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [ffba_pkg::DATA_W-1:0] cfg_data
);

	localparam int IW = $clog2(MAX_BLOCKS);
	localparam int EW = ADDR_WIDTH + ffba_pkg::SIZE_W + 1;

	ffba_pkg::cfg_t cfg_q;
	logic base_wr;
	logic mem_we;
	logic [IW-1:0] mem_waddr, mem_raddr;
	logic [EW-1:0] mem_wdata, mem_rdata;

	// Configuration registers; codes beyond the list are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.heap_base <= ffba_pkg::HEAP_BASE_RST;
			cfg_q.header_size <= ffba_pkg::HEADER_SIZE_RST;
			cfg_q.copy_threshold <= ffba_pkg::COPY_THRESHOLD_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				ffba_pkg::CFG_HEAP_BASE: cfg_q.heap_base <= cfg_data;
				ffba_pkg::CFG_HEADER_SIZE: cfg_q.header_size <= cfg_data[ffba_pkg::HDR_W-1:0];
				ffba_pkg::CFG_COPY_THRESHOLD:
					cfg_q.copy_threshold <= cfg_data[ffba_pkg::SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	// The sequencer reloads the break pointer when the heap base changes
	// while the table is empty.
	assign base_wr = cfg_we && (cfg_index == ffba_pkg::CFG_HEAP_BASE);

	ffba_ctrl #(
		.MAX_BLOCKS(MAX_BLOCKS),
		.ADDR_WIDTH(ADDR_WIDTH)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.base_wr(base_wr),
		.base_data(cfg_data),
		.req(req),
		.rsp(rsp),
		.mem_we(mem_we),
		.mem_waddr(mem_waddr),
		.mem_wdata(mem_wdata),
		.mem_raddr(mem_raddr),
		.mem_rdata(mem_rdata)
	);

	ffba_table #(
		.DEPTH(MAX_BLOCKS),
		.EW(EW)
	) u_table (
		.clk(clk),
		.we(mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

endmodule
